FILE: rtl/core/mpb_pkg.sv
package mpb_pkg;

   // Data path
   localparam int DATA_BITS = 32;
   typedef logic signed [DATA_BITS-1:0] data_type;
   localparam data_type DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

   // Plane geometry
   localparam int MAX_WIDTH = 128;
   localparam int SIZE_BITS = 8;
   localparam int POS_BITS  = $clog2(MAX_WIDTH);
   localparam int ORD_BITS  = POS_BITS - 1;
   localparam int OW_BITS   = POS_BITS;
   localparam logic [SIZE_BITS-1:0] SIZE_MAX   = SIZE_BITS'(MAX_WIDTH);
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(112);

   // Bias plane
   localparam int BIAS_DEPTH = 4096;
   localparam int BIAS_ABITS = $clog2(BIAS_DEPTH);

   // Opcodes of the request word
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_BIAS  = 1'b1;

   // Control register indexes
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = SIZE_BITS;
   localparam logic [CSR_IDX_BITS-1:0] REG_IN_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IN_WIDTH  = 1'b1;

   // Raster position of one pixel
   typedef struct packed {
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
      logic                row_last;
      logic                col_last;
      logic                plane_last;
   } pos_type;

   function automatic data_type max_data(input data_type a, input data_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] n);
      logic [SIZE_BITS-1:0] r;
      r = n;
      if (n == '0) begin
         r = SIZE_BITS'(1);
      end else if (n > SIZE_MAX) begin
         r = SIZE_MAX;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/mpb_req_if.sv
interface mpb_req_if;
   import mpb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  opcode;
   data_type              pixel;
   logic [BIAS_ABITS-1:0] bias_index;
   data_type              bias_value;

   modport source (output valid, output opcode, output pixel, output bias_index,
                   output bias_value, input ready);
   modport sink   (input valid, input opcode, input pixel, input bias_index,
                   input bias_value, output ready);
endinterface

FILE: rtl/core/mpb_rsp_if.sv
interface mpb_rsp_if;
   import mpb_pkg::*;

   logic                valid;
   logic                ready;
   data_type            sum;
   logic [ORD_BITS-1:0] out_row;
   logic [ORD_BITS-1:0] out_col;
   logic                plane_last;

   modport source (output valid, output sum, output out_row, output out_col,
                   output plane_last, input ready);
   modport sink   (input valid, input sum, input out_row, input out_col,
                   input plane_last, output ready);
endinterface

FILE: rtl/core/mpb_raster.sv
module mpb_raster (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mpb_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [mpb_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                step,
   output mpb_pkg::pos_type                    pos,
   output logic [mpb_pkg::OW_BITS-1:0]         out_width
);
   import mpb_pkg::*;

   logic [SIZE_BITS-1:0] in_height_ff, in_height_in;
   logic [SIZE_BITS-1:0] in_width_ff, in_width_in;
   logic [POS_BITS-1:0]  row_ff, row_in;
   logic [POS_BITS-1:0]  col_ff, col_in;
   logic [SIZE_BITS-1:0] height, width;
   logic [SIZE_BITS:0]   width_sum;
   logic                 wrap;
   logic [POS_BITS-1:0]  cur_row, cur_col;

   // Effective size and current position
   always_comb begin
      height    = clamp_size(in_height_ff);
      width     = clamp_size(in_width_ff);
      width_sum = {1'b0, width} + (SIZE_BITS+1)'(1);
      out_width = width_sum[OW_BITS:1];
      wrap      = ({1'b0, row_ff} >= height) || ({1'b0, col_ff} >= width);
      cur_row   = wrap ? '0 : row_ff;
      cur_col   = wrap ? '0 : col_ff;
      pos.row        = cur_row;
      pos.col        = cur_col;
      pos.row_last   = ({1'b0, cur_row} == (height - SIZE_BITS'(1)));
      pos.col_last   = ({1'b0, cur_col} == (width - SIZE_BITS'(1)));
      pos.plane_last = pos.row_last && pos.col_last;
   end

   // Latch sizes; restart the plane on any size write
   always_comb begin
      in_height_in = in_height_ff;
      in_width_in  = in_width_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      priority if (csr_wr_en) begin
         if (csr_index == REG_IN_HEIGHT) begin
            in_height_in = csr_wdata;
         end
         if (csr_index == REG_IN_WIDTH) begin
            in_width_in = csr_wdata;
         end
         row_in = '0;
         col_in = '0;
      end else if (step) begin
         if (pos.col_last) begin
            col_in = '0;
            row_in = pos.row_last ? '0 : (cur_row + POS_BITS'(1));
         end else begin
            col_in = cur_col + POS_BITS'(1);
            row_in = cur_row;
         end
      end else begin
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff <= SIZE_RESET;
         in_width_ff  <= SIZE_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         in_height_ff <= in_height_in;
         in_width_ff  <= in_width_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

`ifndef SYNTHESIS
   a_row_in_plane: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} < height)
      else $error("row counter beyond plane height");
   a_col_wraps: assert property (@(posedge clock) disable iff (reset)
      step && pos.col_last |=> col_ff == '0)
      else $error("column counter did not wrap at line end");
`endif

endmodule

FILE: rtl/core/mpb_bias_ram.sv
module mpb_bias_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [mpb_pkg::BIAS_ABITS-1:0]    wr_index,
   input  mpb_pkg::data_type                 wr_data,
   input  logic                              rd_en,
   input  mpb_pkg::pos_type                  pos,
   input  logic [mpb_pkg::OW_BITS-1:0]       out_width,
   output mpb_pkg::data_type                 rd_data
);
   import mpb_pkg::*;

   localparam int PROD_BITS = ORD_BITS + OW_BITS;

   data_type              bias_mem [BIAS_DEPTH];
   data_type              rd_data_ff;
   logic [PROD_BITS-1:0]  addr_full;
   logic [BIAS_ABITS-1:0] rd_addr;

   // Entry of the pooled output that this pixel belongs to
   always_comb begin
      addr_full = (PROD_BITS'(pos.row[POS_BITS-1:1]) * PROD_BITS'(out_width))
                  + PROD_BITS'(pos.col[POS_BITS-1:1]);
      rd_addr   = addr_full[BIAS_ABITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bias_mem[wr_index] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bias_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/mpb_pool.sv
module mpb_pool (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               move,
   input  mpb_pkg::data_type  pixel_in,
   input  mpb_pkg::pos_type   pos_in,
   output logic               hdone,
   output mpb_pkg::data_type  hmax,
   output mpb_pkg::pos_type   pos_out
);
   import mpb_pkg::*;

   data_type band_mem   [MAX_WIDTH];
   data_type shared_mem [MAX_WIDTH];

   data_type band_rd_ff, shared_rd_ff;
   data_type fwd_data_ff;
   logic     fwd_band_ff, fwd_shared_ff;
   data_type pixel_ff;
   pos_type  pos_ff;
   data_type run_max_ff, shared_col_max_ff;

   data_type band_q, shared_q, vmax, wr_data;
   logic     vdone, row_zero, col_zero, row_odd, col_odd;

   // Column maximum over the band, then the horizontal window
   always_comb begin
      row_odd  = pos_ff.row[0];
      col_odd  = pos_ff.col[0];
      row_zero = (pos_ff.row == '0);
      col_zero = (pos_ff.col == '0);
      band_q   = fwd_band_ff ? fwd_data_ff : band_rd_ff;
      shared_q = fwd_shared_ff ? fwd_data_ff : shared_rd_ff;
      if (row_odd) begin
         vmax    = max_data(band_q, pixel_ff);
         vdone   = 1'b1;
         wr_data = pixel_ff;
      end else begin
         vmax    = row_zero ? pixel_ff : max_data(shared_q, pixel_ff);
         vdone   = pos_ff.row_last;
         wr_data = vmax;
      end
      if (col_odd) begin
         hmax  = max_data(run_max_ff, vmax);
         hdone = vdone;
      end else begin
         hmax  = col_zero ? vmax : max_data(shared_col_max_ff, vmax);
         hdone = vdone && pos_ff.col_last;
      end
   end

   assign pos_out = pos_ff;

   // Line stores: read on load, write back when the word leaves
   always_ff @(posedge clock) begin
      if (move && !pos_ff.row[0]) begin
         band_mem[pos_ff.col] <= wr_data;
      end
      if (move && pos_ff.row[0]) begin
         shared_mem[pos_ff.col] <= wr_data;
      end
      if (load) begin
         band_rd_ff   <= band_mem[pos_in.col];
         shared_rd_ff <= shared_mem[pos_in.col];
         pixel_ff     <= pixel_in;
         pos_ff       <= pos_in;
      end
      if (move) begin
         fwd_data_ff <= wr_data;
      end
   end

   // Bypass a write that lands in the same cycle as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_band_ff   <= 1'b0;
         fwd_shared_ff <= 1'b0;
      end else if (load) begin
         fwd_band_ff   <= move && !pos_ff.row[0] && (pos_ff.col == pos_in.col);
         fwd_shared_ff <= move && pos_ff.row[0] && (pos_ff.col == pos_in.col);
      end
   end

   // Horizontal running state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_max_ff        <= DATA_MIN;
         shared_col_max_ff <= DATA_MIN;
      end else if (move && vdone) begin
         if (pos_ff.col[0]) begin
            shared_col_max_ff <= vmax;
         end else begin
            run_max_ff <= hmax;
         end
      end
   end

endmodule

FILE: rtl/core/maxpool3x3_s2_bias_add_core.sv
// 3x3 max pooling, stride 2, one pixel of padding, followed by a bias add.
// req_chan carries request words: opcode OP_PIXEL streams one signed pixel of
// the current channel plane in raster order, opcode OP_BIAS writes one entry
// of the bias plane (index out_row*out_width+out_col). Bias words produce no
// result. rsp_chan returns one word per finished window: the wrapped sum of
// the window maximum and its bias, the pooled coordinates and plane_last on
// the final window of the plane. The csr_ port sets in_height (index 0) and
// in_width (index 1); a write restarts the plane at row 0, column 0. Write
// it only while the block is idle.
// Throughput: one request word per cycle while the receiver keeps up; line
// stores take a read and a write per cycle, the bias memory a read or a write.
// The closing pixel passes the pool stage register, then the output register.
// Reset restores a 112x112 plane, clears the position and pipeline valids;
// line and bias stores are not cleared (load the bias plane first).
// When the receiver stalls, the output register holds its word and one
// more pixel can still enter the stage before it; then req_chan.ready drops.
module maxpool3x3_s2_bias_add_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [mpb_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mpb_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   mpb_req_if.sink                           req_chan,
   mpb_rsp_if.source                         rsp_chan
);
   import mpb_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   data_type            sum_ff;
   logic [ORD_BITS-1:0] out_row_ff, out_col_ff;
   logic                plane_last_ff;

   logic                out_free, s1_move, req_fire, pix_accept, bias_write;
   pos_type             cur_pos, s1_pos;
   logic [OW_BITS-1:0]  out_width;
   logic                hdone;
   data_type            hmax, bias_rd;

   // Handshake between stages
   always_comb begin
      out_free       = !rsp_valid_ff || rsp_chan.ready;
      s1_move        = s1_valid_ff && out_free;
      req_chan.ready = !s1_valid_ff || out_free;
      req_fire       = req_chan.valid && req_chan.ready;
      pix_accept     = req_fire && (req_chan.opcode == OP_PIXEL);
      bias_write     = req_fire && (req_chan.opcode == OP_BIAS);
   end

   mpb_raster u_raster (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (pix_accept),
      .pos       (cur_pos),
      .out_width (out_width)
   );

   mpb_bias_ram u_bias (
      .clock     (clock),
      .wr_en     (bias_write),
      .wr_index  (req_chan.bias_index),
      .wr_data   (req_chan.bias_value),
      .rd_en     (pix_accept),
      .pos       (cur_pos),
      .out_width (out_width),
      .rd_data   (bias_rd)
   );

   mpb_pool u_pool (
      .clock    (clock),
      .reset    (reset),
      .load     (pix_accept),
      .move     (s1_move),
      .pixel_in (req_chan.pixel),
      .pos_in   (cur_pos),
      .hdone    (hdone),
      .hmax     (hmax),
      .pos_out  (s1_pos)
   );

   // Advance valids
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pix_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = hdone;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (s1_move && hdone) begin
         sum_ff        <= hmax + bias_rd;
         out_row_ff    <= s1_pos.row[POS_BITS-1:1];
         out_col_ff    <= s1_pos.col[POS_BITS-1:1];
         plane_last_ff <= s1_pos.plane_last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sum        = sum_ff;
   assign rsp_chan.out_row    = out_row_ff;
   assign rsp_chan.out_col    = out_col_ff;
   assign rsp_chan.plane_last = plane_last_ff;

`ifndef SYNTHESIS
   a_pixel_enters: assert property (@(posedge clock) disable iff (reset)
      pix_accept |=> s1_valid_ff)
      else $error("accepted pixel did not enter the pool stage");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_chan.ready)
      else $error("request refused with empty pool stage");
`endif

endmodule
